@@ rtl/plen_pkg.sv @@
// ============================================================================
// plen_pkg - shared types and constants for the positional list engine
// Holds the request kinds, response status codes, channel widths and the
// per-cell command group handed from the top level to every list cell.
// ============================================================================
package plen_pkg;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_GET    = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Response status codes carried on rsp_tuser.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Field widths fixed by the channel format.
   localparam int KIND_BITS     = 2;
   localparam int POSITION_BITS = 8;
   localparam int WORD_BITS     = 64;
   localparam int STATUS_BITS   = 2;
   localparam int LENGTH_BITS   = 7;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 72;

   // Shift command broadcast to every cell in the chain.
   typedef struct packed {
      logic ins;   // open a slot at the index and load the new word
      logic del;   // close the slot at the index
   } cell_cmd_type;

endpackage

@@ rtl/plen_cell.sv @@
// ============================================================================
// plen_cell - one storage cell of the positional list chain
// Holds one list entry. On an insert below it, it takes its lower neighbor's
// word (the new word if the index is its own); on a delete at or below it,
// its upper neighbor's word. It drives its word onto the read bus if selected.
// ============================================================================
module plen_cell #(
   parameter int ENTRY_BITS = 64,
   parameter int IDX_BITS   = 6,
   parameter int INDEX      = 0
) (
   input  logic                      clock,
   input  plen_pkg::cell_cmd_type    cmd,
   input  logic [IDX_BITS-1:0]       idx,
   input  logic [ENTRY_BITS-1:0]     load_value,
   input  logic [ENTRY_BITS-1:0]     prev_value,
   input  logic [ENTRY_BITS-1:0]     next_value,
   output logic [ENTRY_BITS-1:0]     value,
   output logic [ENTRY_BITS-1:0]     read_part
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

   logic [ENTRY_BITS-1:0] value_ff;
   logic [ENTRY_BITS-1:0] value_in;

   // Choose this cell's next word from the shift command.
   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (idx == MY_IDX) begin
            value_in = load_value;
         end else if (idx < MY_IDX) begin
            value_in = prev_value;
         end
      end else if (cmd.del && (idx <= MY_IDX)) begin
         value_in = next_value;
      end
   end

   // Entry storage; contents are undefined until written.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_part = (idx == MY_IDX) ? value_ff : '0;

endmodule

@@ rtl/positional_list_engine.sv @@
// ============================================================================
// positional_list_engine - ordered list with insert/delete/get by position
// Keeps up to CAPACITY entries in a chain of cells addressed by 1-based
// position, answering every request with a status, read data and length.
// ============================================================================
// The engine accepts one transaction per cycle for as long as the response
// side keeps taking results: on an accepted request all cells shift toward
// or away from the addressed position in parallel, and the response appears
// in an output register on the next cycle. A new request is accepted while
// that register is empty or in the same cycle that its response is taken,
// so a stalled response side holds off the request side. A get reads
// entries already updated by the preceding request. Cell storage is not
// cleared at reset; only the entry count and response valid flag are, so the
// engine is ready in the first cycle after reset with no clearing pass.
module positional_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] position, [71:8] entry_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] read_value, [70:64] list_length,
                                    // [71] list_empty
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS = ((CNT_BITS > plen_pkg::POSITION_BITS) ?
                              CNT_BITS : plen_pkg::POSITION_BITS) + 1;
   localparam int LEN_BITS = (CNT_BITS > plen_pkg::LENGTH_BITS) ?
                             CNT_BITS : plen_pkg::LENGTH_BITS;
   localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);

   // Request fields.
   logic                           req_accept;
   plen_pkg::kind_type             req_kind;
   logic [plen_pkg::POSITION_BITS-1:0] req_position;
   logic [ENTRY_BITS-1:0]          req_word;

   // List state and response register.
   logic [CNT_BITS-1:0]            count_ff;
   logic [CNT_BITS-1:0]            count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [plen_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [plen_pkg::RSP_DATA_BITS-1:0] rsp_data_in;
   logic [plen_pkg::STATUS_BITS-1:0]   rsp_user_ff;
   logic [plen_pkg::STATUS_BITS-1:0]   rsp_user_in;

   // Decode and chain control.
   logic [CMP_BITS-1:0]            pos_ext;
   logic [CMP_BITS-1:0]            cnt_ext;
   logic [CMP_BITS-1:0]            pos_m1;
   logic [IDX_BITS-1:0]            cell_idx;
   logic                           pos_zero;
   logic                           is_full;
   plen_pkg::status_type           status;
   plen_pkg::cell_cmd_type         cell_cmd;
   logic                           get_ok;
   logic [ENTRY_BITS-1:0]          read_word;
   logic [LEN_BITS-1:0]            len_ext;

   logic [ENTRY_BITS-1:0]          cell_value [CAPACITY];
   logic [ENTRY_BITS-1:0]          cell_read  [CAPACITY];

   // Channel handshakes.
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_accept   = req_tvalid && req_tready;
   assign req_kind     = plen_pkg::kind_type'(req_tuser);
   assign req_position = req_tdata[plen_pkg::POSITION_BITS-1:0];
   assign req_word     = req_tdata[plen_pkg::POSITION_BITS +: ENTRY_BITS];

   // Position range checks against the current entry count.
   assign pos_ext  = CMP_BITS'(req_position);
   assign cnt_ext  = CMP_BITS'(count_ff);
   assign pos_m1   = pos_ext - CMP_BITS'(1);
   assign cell_idx = pos_m1[IDX_BITS-1:0];
   assign pos_zero = (req_position == '0);
   assign is_full  = (count_ff == CAP_COUNT);

   // Request decode: status, shift command and next count.
   always_comb begin
      status   = plen_pkg::ST_OK;
      cell_cmd = '0;
      get_ok   = 1'b0;
      count_in = count_ff;
      case (req_kind)
         plen_pkg::KIND_INSERT: begin
            if (pos_zero || (pos_ext > cnt_ext + CMP_BITS'(1))) begin
               status = plen_pkg::ST_BAD_POS;
            end else if (is_full) begin
               status = plen_pkg::ST_FULL;
            end else begin
               cell_cmd.ins = req_accept;
               if (req_accept) begin
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
         end
         plen_pkg::KIND_DELETE: begin
            if (pos_zero || (pos_ext > cnt_ext)) begin
               status = plen_pkg::ST_BAD_POS;
            end else begin
               cell_cmd.del = req_accept;
               if (req_accept) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
         end
         plen_pkg::KIND_GET: begin
            if (pos_zero || (pos_ext > cnt_ext)) begin
               status = plen_pkg::ST_BAD_POS;
            end else begin
               get_ok = 1'b1;
            end
         end
         plen_pkg::KIND_CLEAR: begin
            if (req_accept) begin
               count_in = '0;
            end
         end
         default: begin
            status = plen_pkg::ST_OK;
         end
      endcase
   end

   // Chain of entry cells; each one takes shifted words only from its neighbors.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ENTRY_BITS-1:0] prev_word;
      logic [ENTRY_BITS-1:0] next_word;

      if (k == 0) begin : g_first
         assign prev_word = '0;
      end else begin : g_mid_prev
         assign prev_word = cell_value[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign next_word = '0;
      end else begin : g_mid_next
         assign next_word = cell_value[k+1];
      end

      plen_cell #(
         .ENTRY_BITS (ENTRY_BITS),
         .IDX_BITS   (IDX_BITS),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .idx        (cell_idx),
         .load_value (req_word),
         .prev_value (prev_word),
         .next_value (next_word),
         .value      (cell_value[k]),
         .read_part  (cell_read[k])
      );
   end

   // Read bus: only the selected cell drives its word; all others drive zero.
   always_comb begin
      read_word = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_word = read_word | cell_read[k];
      end
   end

   // Response contents for the transaction being accepted.
   assign len_ext = LEN_BITS'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(count_in == '0),
                         len_ext[plen_pkg::LENGTH_BITS-1:0],
                         plen_pkg::WORD_BITS'(get_ok ? read_word : '0)};
         rsp_user_in  = status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
